/* design/priority_retry_tx_scheduler_assert.svh */
// Assertion macros for the scheduler RTL.
`ifndef PRIORITY_RETRY_TX_SCHEDULER_ASSERT_SVH
`define PRIORITY_RETRY_TX_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/prts_pkg.sv */
package prts_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TAG_W   = 16;
    localparam int LEN_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int LIM_W   = 8;
    localparam int BASE_W  = 10;
    localparam int STEP_W  = 8;
    localparam int DELAY_W = 17;
    localparam int PROD_W  = STEP_W + LIM_W;

    localparam logic [BASE_W-1:0] BASE_RST = 10'd60;
    localparam logic [STEP_W-1:0] STEP_RST = 8'd40;

    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_SEND = 2'd1;
    localparam logic [1:0] ACT_ACK  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_NOCUR = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [PRIO_W-1:0] prio;
        logic [LIM_W-1:0]  limit;
        logic [LIM_W-1:0]  sends;
    } t_entry;

    // One index serves the read, the removal and the send count update.
    typedef struct packed {
        logic             app_en;
        logic             rm_en;
        logic             inc_en;
        logic [IDX_W-1:0] idx;
    } t_tbl_ctrl;

endpackage

/* design/prts_table.sv */
module prts_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  prts_pkg::t_tbl_ctrl             i_ctrl,
    input  prts_pkg::t_entry                i_app,
    output prts_pkg::t_entry                o_rd,
    output logic [prts_pkg::CNT_W-1:0]      o_cnt
);

    prts_pkg::t_entry r_ent [prts_pkg::QUEUE_DEPTH];
    prts_pkg::t_entry n_ent [prts_pkg::QUEUE_DEPTH];
    logic [prts_pkg::CNT_W-1:0] r_cnt;
    logic [prts_pkg::CNT_W-1:0] n_cnt;

    always_comb begin
        n_ent = r_ent;
        n_cnt = r_cnt;
        if (i_ctrl.rm_en) begin
            // close the gap: later entries move down by one
            for (int i = 0; i < prts_pkg::QUEUE_DEPTH - 1; i++) begin
                if (prts_pkg::IDX_W'(i) >= i_ctrl.idx) begin
                    n_ent[i] = r_ent[i + 1];
                end
            end
            n_cnt = r_cnt - prts_pkg::CNT_W'(1);
        end
        if (i_ctrl.app_en) begin
            n_ent[r_cnt[prts_pkg::IDX_W-1:0]] = i_app;
            n_cnt = r_cnt + prts_pkg::CNT_W'(1);
        end
        if (i_ctrl.inc_en) begin
            n_ent[i_ctrl.idx].sends = r_ent[i_ctrl.idx].sends + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_rd  = r_ent[i_ctrl.idx];
    assign o_cnt = r_cnt;

endmodule

/* design/priority_retry_tx_scheduler.sv */
//  channel  | direction | tdata (low bit up)                      | tuser
//  ---------+-----------+-----------------------------------------+----------------------
//  s_axis   | in        | payload_tag, msg_len, retry_limit,      | action
//           |           | msg_priority                            |
//  m_axis   | out       | send_tag, send_len, delay_ms, retired   | status, send_valid
//  cfg      | in        | index 0 backoff_base, 1 backoff_step    | -
//
//  Enqueue and acknowledge pass from acceptance through the execute and finish states; a send
//  passes through execute, send, multiply and finish, with a scan state before send when a new
//  message must be selected, since one priority comparator walks the table one entry a cycle.
//  The block takes one transaction at a time; s_axis_tready is high only when idle.
//  A result waits in an internal register while m_axis is stalled; the output register
//  lets the next transaction in while the previous result is still waiting.
//  Reset (synchronous, active low) empties the queue and restores the backoff values.
module priority_retry_tx_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // payload_tag, msg_len, retry_limit, msg_priority
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // send_tag, send_len, delay_ms, retired, zero pad
    output logic [2:0]  m_axis_tuser,   // status, send_valid
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [9:0]  i_cfg_wdata
);

    `include "priority_retry_tx_scheduler_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SEND = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam int IW = prts_pkg::IDX_W;
    localparam int CW = prts_pkg::CNT_W;

    logic [2:0] r_state, n_state;
    logic [1:0] r_act, n_act;
    prts_pkg::t_entry r_in, n_in;
    logic          r_held, n_held;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_best, n_best;
    logic [prts_pkg::PRIO_W-1:0] r_best_prio, n_best_prio;
    logic [prts_pkg::BASE_W-1:0] r_base;
    logic [prts_pkg::STEP_W-1:0] r_step;
    logic [prts_pkg::LIM_W-1:0]  r_mul_cnt, n_mul_cnt;

    logic [1:0]  r_res_status, n_res_status;
    logic        r_res_sv, n_res_sv;
    logic [15:0] r_res_tag, n_res_tag;
    logic [15:0] r_res_len, n_res_len;
    logic [16:0] r_res_delay, n_res_delay;
    logic        r_res_ret, n_res_ret;

    logic        r_out_valid, n_out_valid;
    logic [55:0] r_out_tdata, n_out_tdata;
    logic [2:0]  r_out_tuser, n_out_tuser;

    prts_pkg::t_tbl_ctrl tbl_ctrl;
    prts_pkg::t_entry    tbl_rd;
    logic [CW-1:0]       tbl_cnt;

    logic                        accept;
    logic                        send_inc;
    logic                        send_retire;
    logic [prts_pkg::LIM_W-1:0]  send_cnt;
    logic [prts_pkg::PROD_W-1:0] mul_prod;

    prts_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (tbl_ctrl),
        .i_app   (r_in),
        .o_rd    (tbl_rd),
        .o_cnt   (tbl_cnt)
    );

    assign accept = s_axis_tvalid && s_axis_tready;

    assign send_inc    = tbl_rd.limit > tbl_rd.sends;
    assign send_cnt    = send_inc ? tbl_rd.sends + 8'd1 : tbl_rd.sends;
    assign send_retire = send_cnt >= tbl_rd.limit;
    assign mul_prod    = r_step * r_mul_cnt;

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_in         = r_in;
        n_held       = r_held;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_best       = r_best;
        n_best_prio  = r_best_prio;
        n_mul_cnt    = r_mul_cnt;
        n_res_status = r_res_status;
        n_res_sv     = r_res_sv;
        n_res_tag    = r_res_tag;
        n_res_len    = r_res_len;
        n_res_delay  = r_res_delay;
        n_res_ret    = r_res_ret;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_tdata  = r_out_tdata;
        n_out_tuser  = r_out_tuser;
        tbl_ctrl     = '0;
        tbl_ctrl.idx = r_cur;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act          = s_axis_tuser;
                    n_in.tag       = s_axis_tdata[15:0];
                    n_in.len       = s_axis_tdata[31:16];
                    n_in.limit     = s_axis_tdata[39:32];
                    n_in.prio      = s_axis_tdata[47:40];
                    n_in.sends     = '0;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = prts_pkg::STAT_OK;
                n_res_sv     = 1'b0;
                n_res_tag    = '0;
                n_res_len    = '0;
                n_res_delay  = '0;
                n_res_ret    = 1'b0;
                n_state      = S_FIN;
                case (r_act)
                    prts_pkg::ACT_ENQ: begin
                        if (tbl_cnt >= CW'(prts_pkg::QUEUE_DEPTH)) begin
                            n_res_status = prts_pkg::STAT_FULL;
                        end else begin
                            tbl_ctrl.app_en = 1'b1;
                        end
                    end
                    prts_pkg::ACT_SEND: begin
                        if (!r_held && tbl_cnt != '0) begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end else if (r_held && CW'(r_cur) < tbl_cnt) begin
                            n_state = S_SEND;
                        end else begin
                            n_held       = 1'b0;
                            n_res_status = prts_pkg::STAT_EMPTY;
                        end
                    end
                    prts_pkg::ACT_ACK: begin
                        if (r_held && CW'(r_cur) < tbl_cnt) begin
                            tbl_ctrl.rm_en = 1'b1;
                            n_res_ret      = 1'b1;
                        end else begin
                            n_res_status = prts_pkg::STAT_NOCUR;
                        end
                        n_held = 1'b0;
                        n_cur  = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // strict compare keeps the earliest entry on a tie
                tbl_ctrl.idx = r_idx;
                if (r_idx == '0 || tbl_rd.prio > r_best_prio) begin
                    n_best      = r_idx;
                    n_best_prio = tbl_rd.prio;
                end
                n_idx = r_idx + IW'(1);
                if (CW'(r_idx) + CW'(1) == tbl_cnt) begin
                    n_cur   = n_best;
                    n_held  = 1'b1;
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                n_res_sv  = 1'b1;
                n_res_tag = tbl_rd.tag;
                n_res_len = tbl_rd.len;
                n_mul_cnt = send_cnt;
                if (send_retire) begin
                    tbl_ctrl.rm_en = 1'b1;
                    n_held         = 1'b0;
                    n_cur          = '0;
                    n_res_ret      = 1'b1;
                end else if (send_inc) begin
                    tbl_ctrl.inc_en = 1'b1;
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                n_res_delay = prts_pkg::DELAY_W'(r_base) + prts_pkg::DELAY_W'(mul_prod);
                n_state     = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = {6'd0, r_res_ret, r_res_delay, r_res_len, r_res_tag};
                    n_out_tuser = {r_res_sv, r_res_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= 1'b0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            r_base      <= prts_pkg::BASE_RST;
            r_step      <= prts_pkg::STEP_RST;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'b0) begin
                    r_base <= i_cfg_wdata;
                end else begin
                    r_step <= i_cfg_wdata[prts_pkg::STEP_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_in         <= n_in;
        r_idx        <= n_idx;
        r_best       <= n_best;
        r_best_prio  <= n_best_prio;
        r_mul_cnt    <= n_mul_cnt;
        r_res_status <= n_res_status;
        r_res_sv     <= n_res_sv;
        r_res_tag    <= n_res_tag;
        r_res_len    <= n_res_len;
        r_res_delay  <= n_res_delay;
        r_res_ret    <= n_res_ret;
        r_out_tdata  <= n_out_tdata;
        r_out_tuser  <= n_out_tuser;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    `PRTS_ASSERT_NOW(a_cnt_bound, 1'b1, tbl_cnt <= CW'(prts_pkg::QUEUE_DEPTH), "fill count overflow")
    `PRTS_ASSERT_NOW(a_cur_in_queue, r_held, CW'(r_cur) < tbl_cnt, "current message outside queue")
    `PRTS_ASSERT_NEXT(a_retire_shrinks, r_state == S_SEND && send_retire, tbl_cnt == $past(tbl_cnt) - CW'(1), "retire did not shrink queue")
    `PRTS_ASSERT_NEXT(a_fin_holds, r_state == S_FIN && r_out_valid && !m_axis_tready, r_state == S_FIN, "result dropped while output stalled")
    `PRTS_ASSERT_NOW(a_send_ok, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == prts_pkg::STAT_OK, "send with error status")

endmodule

/* test/priority_retry_tx_scheduler_test.sv */
module priority_retry_tx_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NONE      = 2'd3;   // unused action code, ignored by the block
    localparam logic       REG_BASE      = 1'b0;
    localparam logic       REG_STEP      = 1'b1;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic [1:0]                  action;
        logic [prts_pkg::TAG_W-1:0]  tag;
        logic [prts_pkg::LEN_W-1:0]  len;
        logic [prts_pkg::LIM_W-1:0]  limit;
        logic [prts_pkg::PRIO_W-1:0] prio;
    } t_tx_request;

    typedef struct packed {
        logic [1:0]                   status;
        logic                         sent;
        logic [prts_pkg::TAG_W-1:0]   tag;
        logic [prts_pkg::LEN_W-1:0]   len;
        logic [prts_pkg::DELAY_W-1:0] delay;
        logic                         retired;
    } t_tx_outcome;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we   = 1'b0;
    logic        cfg_idx  = 1'b0;
    logic [9:0]  cfg_wdata = '0;

    // Scheduler state mirror
    logic [prts_pkg::TAG_W-1:0]  q_tag   [prts_pkg::QUEUE_DEPTH];
    logic [prts_pkg::LEN_W-1:0]  q_len   [prts_pkg::QUEUE_DEPTH];
    logic [prts_pkg::PRIO_W-1:0] q_prio  [prts_pkg::QUEUE_DEPTH];
    logic [prts_pkg::LIM_W-1:0]  q_limit [prts_pkg::QUEUE_DEPTH];
    logic [prts_pkg::LIM_W-1:0]  q_sends [prts_pkg::QUEUE_DEPTH];
    int                          q_fill   = 0;
    int                          cur_idx  = 0;
    bit                          cur_held = 1'b0;
    logic [prts_pkg::BASE_W-1:0] cfg_base = prts_pkg::BASE_RST;
    logic [prts_pkg::STEP_W-1:0] cfg_step = prts_pkg::STEP_RST;

    t_tx_outcome pending_outcomes[$];
    t_tx_outcome head_outcome;
    int          error_count  = 0;
    int          quiet_cycles = 0;
    bit          idle_on      = 1'b0;
    int          burst_left   = 0;
    int          hold_left    = 0;

    priority_retry_tx_scheduler dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic void drop_entry(int idx);
        int i;
        for (i = idx; i < q_fill - 1; i++) begin
            q_tag[i]   = q_tag[i + 1];
            q_len[i]   = q_len[i + 1];
            q_prio[i]  = q_prio[i + 1];
            q_limit[i] = q_limit[i + 1];
            q_sends[i] = q_sends[i + 1];
        end
        q_fill--;
    endfunction

    function automatic t_tx_outcome schedule_outcome(t_tx_request req);
        t_tx_outcome                  o;
        int                           i;
        int                           best;
        int                           c;
        logic [prts_pkg::DELAY_W-1:0] d_base;
        logic [prts_pkg::DELAY_W-1:0] d_step;
        logic [prts_pkg::DELAY_W-1:0] d_cnt;
        o = '0;
        case (req.action)
            prts_pkg::ACT_ENQ: begin
                if (q_fill >= prts_pkg::QUEUE_DEPTH) begin
                    o.status = prts_pkg::STAT_FULL;
                end else begin
                    q_tag[q_fill]   = req.tag;
                    q_len[q_fill]   = req.len;
                    q_limit[q_fill] = req.limit;
                    q_prio[q_fill]  = req.prio;
                    q_sends[q_fill] = '0;
                    q_fill++;
                end
            end
            prts_pkg::ACT_SEND: begin
                // select only when nothing is current; strict compare keeps the earliest
                if (!cur_held && q_fill > 0) begin
                    best = 0;
                    for (i = 1; i < q_fill; i++)
                        if (q_prio[i] > q_prio[best])
                            best = i;
                    cur_idx  = best;
                    cur_held = 1'b1;
                end
                if (cur_held && cur_idx < q_fill) begin
                    c = cur_idx;
                    if (q_limit[c] > q_sends[c])
                        q_sends[c]++;
                    d_base  = prts_pkg::DELAY_W'(cfg_base);
                    d_step  = prts_pkg::DELAY_W'(cfg_step);
                    d_cnt   = prts_pkg::DELAY_W'(q_sends[c]);
                    o.sent  = 1'b1;
                    o.tag   = q_tag[c];
                    o.len   = q_len[c];
                    o.delay = d_base + d_step * d_cnt;
                    if (q_sends[c] >= q_limit[c]) begin
                        drop_entry(c);
                        cur_held  = 1'b0;
                        cur_idx   = 0;
                        o.retired = 1'b1;
                    end
                end else begin
                    cur_held = 1'b0;
                    o.status = prts_pkg::STAT_EMPTY;
                end
            end
            prts_pkg::ACT_ACK: begin
                if (cur_held && cur_idx < q_fill) begin
                    drop_entry(cur_idx);
                    o.retired = 1'b1;
                end else begin
                    o.status = prts_pkg::STAT_NOCUR;
                end
                cur_held = 1'b0;
                cur_idx  = 0;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_tx_request make_request(logic [1:0] action,
                                                 logic [prts_pkg::TAG_W-1:0] tag,
                                                 logic [prts_pkg::LEN_W-1:0] len,
                                                 logic [prts_pkg::LIM_W-1:0] limit,
                                                 logic [prts_pkg::PRIO_W-1:0] prio);
        t_tx_request r;
        r.action = action;
        r.tag    = tag;
        r.len    = len;
        r.limit  = limit;
        r.prio   = prio;
        return r;
    endfunction

    function automatic t_tx_request random_request(int enq_pct);
        t_tx_request r;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < enq_pct)
            r.action = prts_pkg::ACT_ENQ;
        else if (pick < enq_pct + (100 - enq_pct) * 7 / 10)
            r.action = prts_pkg::ACT_SEND;
        else if (pick < 97)
            r.action = prts_pkg::ACT_ACK;
        else
            r.action = ACT_NONE;
        r.tag = prts_pkg::TAG_W'($urandom);
        r.len = prts_pkg::LEN_W'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 12)
            r.limit = prts_pkg::LIM_W'($urandom_range(0, 3));
        else if (pick < 19)
            r.limit = prts_pkg::LIM_W'($urandom_range(4, 12));
        else
            r.limit = prts_pkg::LIM_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            r.prio = prts_pkg::PRIO_W'($urandom_range(0, 3));
        else
            r.prio = prts_pkg::PRIO_W'($urandom);
        return r;
    endfunction

    task automatic send_request(t_tx_request req);
        int gap;
        if (idle_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 10);
                s_tvalid  <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req.prio, req.limit, req.len, req.tag};
        s_tuser  <= req.action;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_outcomes.push_back(schedule_outcome(req));
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_outcomes();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] value);
        drain_outcomes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BASE)
            cfg_base = value;
        else
            cfg_step = value[prts_pkg::STEP_W-1:0];
    endtask

    task automatic run_traffic(int count, int enq_pct);
        int k;
        int seg;
        seg = 0;
        for (k = 0; k < count; k++) begin
            if (seg == 0) begin
                seg     = $urandom_range(20, 60);
                idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 4) == 0)
                    drain_outcomes();
            end
            seg--;
            send_request(random_request(enq_pct));
        end
    endtask

    task automatic test_idle_responses();
        idle_on = 1'b1;
        send_request(make_request(prts_pkg::ACT_SEND, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        send_request(make_request(prts_pkg::ACT_ACK, 16'h0000, 16'h0000, 8'h00, 8'h00));
        send_request(make_request(ACT_NONE, 16'hA5A5, 16'h5A5A, 8'h55, 8'hAA));
        // limit 0 still sends once and retires at once
        send_request(make_request(prts_pkg::ACT_ENQ, 16'hFFFF, 16'h0000, 8'h00, 8'h00));
        send_request(make_request(prts_pkg::ACT_SEND, 16'h0000, 16'h0000, 8'h00, 8'h00));
    endtask

    task automatic test_priority_order();
        send_request(make_request(prts_pkg::ACT_ENQ, 16'h0000, 16'hFFFF, 8'd3, 8'd5));
        send_request(make_request(prts_pkg::ACT_ENQ, 16'h1234, 16'h0000, 8'd1, 8'd5));
        send_request(make_request(prts_pkg::ACT_SEND, '0, '0, '0, '0));
        // higher priority arrives while a message is current: no preemption
        send_request(make_request(prts_pkg::ACT_ENQ, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        send_request(make_request(prts_pkg::ACT_SEND, '0, '0, '0, '0));
        send_request(make_request(prts_pkg::ACT_ACK, '0, '0, '0, '0));
        send_request(make_request(prts_pkg::ACT_SEND, '0, '0, '0, '0));
        send_request(make_request(prts_pkg::ACT_ACK, '0, '0, '0, '0));
        send_request(make_request(prts_pkg::ACT_SEND, '0, '0, '0, '0));
    endtask

    task automatic test_queue_full();
        int k;
        for (k = 0; k < prts_pkg::QUEUE_DEPTH; k++)
            send_request(make_request(prts_pkg::ACT_ENQ, prts_pkg::TAG_W'($urandom),
                                      prts_pkg::LEN_W'($urandom),
                                      prts_pkg::LIM_W'($urandom_range(0, 4)),
                                      (k == 3) ? 8'hFF
                                               : prts_pkg::PRIO_W'($urandom_range(0, 254))));
        send_request(make_request(prts_pkg::ACT_ENQ, 16'hBEEF, 16'hCAFE, 8'd1, 8'hFF));
        write_reg(REG_BASE, 10'h3FF);
        write_reg(REG_STEP, 10'h3FF);
        send_request(make_request(prts_pkg::ACT_SEND, '0, '0, '0, '0));
        send_request(make_request(prts_pkg::ACT_ACK, '0, '0, '0, '0));
    endtask

    task automatic test_backoff_sweep();
        write_reg(REG_BASE, 10'd0);
        write_reg(REG_STEP, 10'd0);
        run_traffic(180, 30);
        write_reg(REG_BASE, 10'h3FF);
        run_traffic(180, 45);
        write_reg(REG_BASE, 10'd0);
        write_reg(REG_STEP, 10'hFF);
        run_traffic(180, 30);
        write_reg(REG_BASE, 10'($urandom_range(0, 1023)));
        write_reg(REG_STEP, 10'($urandom_range(0, 1023)));
        run_traffic(180, 40);
        write_reg(REG_BASE, 10'h3FF);
        write_reg(REG_STEP, 10'hFF);
        run_traffic(180, 50);
        write_reg(REG_BASE, 10'd60);
        write_reg(REG_STEP, 10'd40);
        run_traffic(180, 35);
    endtask

    task automatic check_field(string name, logic [prts_pkg::DELAY_W-1:0] want,
                               logic [prts_pkg::DELAY_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected transaction: expected none actual tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                head_outcome = pending_outcomes.pop_front();
                check_field("status", prts_pkg::DELAY_W'(head_outcome.status),
                            prts_pkg::DELAY_W'(m_tuser[1:0]));
                check_field("send_valid", prts_pkg::DELAY_W'(head_outcome.sent),
                            prts_pkg::DELAY_W'(m_tuser[2]));
                check_field("send_tag", prts_pkg::DELAY_W'(head_outcome.tag),
                            prts_pkg::DELAY_W'(m_tdata[15:0]));
                check_field("send_len", prts_pkg::DELAY_W'(head_outcome.len),
                            prts_pkg::DELAY_W'(m_tdata[31:16]));
                check_field("delay_ms", head_outcome.delay, m_tdata[48:32]);
                check_field("retired", prts_pkg::DELAY_W'(head_outcome.retired),
                            prts_pkg::DELAY_W'(m_tdata[49]));
                check_field("pad", '0, prts_pkg::DELAY_W'(m_tdata[55:50]));
            end
        end
    end

    // Receiver: always ready while idle_on is clear, else runs of ready and stall of random length
    always @(posedge clk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
            hold_left = $urandom_range(0, 7);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_responses();
        test_priority_order();
        test_queue_full();
        test_backoff_sweep();
        drain_outcomes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
